// ===== design/string_bucket_hash_core_defines.svh =====
// ----------------------------------------------------------------------------
// string_bucket_hash_core_defines.svh
// Assertion macros for the port-level checker of the hash core.
// ----------------------------------------------------------------------------
`ifndef STRING_BUCKET_HASH_CORE_DEFINES_SVH
`define STRING_BUCKET_HASH_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SBH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbh assertion failed");

// Next-cycle implication, checked outside reset
`define SBH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbh assertion failed");

// Next-cycle implication, checked at every edge including reset
`define SBH_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sbh assertion failed");

`endif

// ===== design/sbh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbh_pkg
// Types and constants shared by the controller and datapath of the hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package sbh_pkg;

    localparam int BYTE_W     = 8;
    localparam int HASH_W     = 24;
    localparam int IDX_W      = 16;
    localparam int STEP_SHIFT = 12;
    localparam int FOLD_SHIFT = 24;
    localparam int DIV_STEPS  = HASH_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] TABLE_SIZE_RST = 16'd127;

    // Controller states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic fold;
        logic start;
        logic step;
        logic load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic zero_byte;
        logic last_step;
    } status_t;

endpackage

`default_nettype wire

// ===== design/string_bucket_hash_core.sv =====
// ----------------------------------------------------------------------------
// string_bucket_hash_core
// Byte-serial string hash with bucket index (hash modulo table size).
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_char_byte carries one name byte per beat. A nonzero
//   byte is folded into the 24-bit running hash as it is accepted, so
//   nonzero bytes stream at one per cycle while s_ready is high. A zero
//   byte ends the name: the hash is latched, the running hash clears, and
//   a one-bit-per-cycle restoring divider forms hash modulo table size.
//   m_valid/m_ready/m_bucket_index/m_raw_hash carries one result beat per
//   terminator. The result lands in the output register once the divide
//   is done and the register is free; s_ready stays low from the
//   terminator beat until that load.
//   If the receiver stalls, the result holds in the output register while
//   the next name streams in; the next terminator waits before loading.
//   cfg_wr_en/cfg_wr_data write the table size; write only while idle.
//   A table size of zero gives bucket index 0.
//   Reset (aresetn low, synchronous) clears the hash, drops m_valid and
//   sets the table size to 127.
// ----------------------------------------------------------------------------
`default_nettype none

module string_bucket_hash_core
    import sbh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_char_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [IDX_W-1:0]       m_bucket_index,
    output logic [HASH_W-1:0]      m_raw_hash
);

    cmd_t    cmd;
    status_t status;

    // Sequencer
    sbh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hash, divider and output register
    sbh_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_char_byte    (s_char_byte),
        .cmd            (cmd),
        .status         (status),
        .m_bucket_index (m_bucket_index),
        .m_raw_hash     (m_raw_hash)
    );

endmodule

`default_nettype wire

// ===== design/sbh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbh_ctrl
// Sequencer: folds bytes, runs the bucket modulo on a terminator and hands
// the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbh_ctrl
    import sbh_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_valid && status.zero_byte) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready   = 1'b0;
        cmd.fold  = 1'b0;
        cmd.start = 1'b0;
        cmd.step  = 1'b0;
        cmd.load  = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                s_ready   = 1'b1;
                cmd.fold  = s_valid && !status.zero_byte;
                cmd.start = s_valid && status.zero_byte;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
            end
            ST_DONE: begin
                cmd.load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Output beat valid: set on load, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sbh_datapath.sv =====
// ----------------------------------------------------------------------------
// sbh_datapath
// Running hash, table size register, bit-serial restoring divider and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbh_datapath
    import sbh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_wr_data,
    input  wire logic [BYTE_W-1:0] s_char_byte,
    input  wire cmd_t              cmd,
    output status_t                status,
    output logic [IDX_W-1:0]       m_bucket_index,
    output logic [HASH_W-1:0]      m_raw_hash
);

    localparam int SUM_W = HASH_W + BYTE_W;

    logic [IDX_W-1:0]  table_size_reg;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] num_reg;
    logic [HASH_W-1:0] raw_hold_reg;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  idx_out_reg;
    logic [HASH_W-1:0] raw_out_reg;

    logic [SUM_W-1:0]  shifted;
    logic [IDX_W:0]    trial;
    logic [IDX_W:0]    diff;

    // Fold one byte: shift by 12, add the byte, xor the top byte into the low bits
    always_comb begin
        shifted   = {hash_reg[SUM_W-STEP_SHIFT-1:0], {STEP_SHIFT{1'b0}}};
        shifted   = shifted | {{(SUM_W-BYTE_W){1'b0}}, s_char_byte};
        hash_next = shifted[HASH_W-1:0]
                  ^ {{(HASH_W-BYTE_W){1'b0}}, shifted[FOLD_SHIFT +: BYTE_W]};
    end

    // One restoring divide step
    always_comb begin
        trial = {rem_reg, num_reg[HASH_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        if (trial >= {1'b0, divisor_reg}) begin
            rem_next = diff[IDX_W-1:0];
        end else begin
            rem_next = trial[IDX_W-1:0];
        end
    end

    assign status.zero_byte = (s_char_byte == '0);
    assign status.last_step = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // Configuration and running hash
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= TABLE_SIZE_RST;
            hash_reg       <= '0;
            cnt_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                table_size_reg <= cfg_wr_data;
            end
            priority if (cmd.fold) begin
                hash_reg <= hash_next;
            end else if (cmd.start) begin
                hash_reg <= '0;
            end else begin
                hash_reg <= hash_reg;
            end
            priority if (cmd.start) begin
                cnt_reg <= '0;
            end else if (cmd.step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= cnt_reg;
            end
        end
    end

    // Divider and output payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            num_reg      <= hash_reg;
            raw_hold_reg <= hash_reg;
            divisor_reg  <= table_size_reg;
            rem_reg      <= '0;
        end else if (cmd.step) begin
            num_reg <= {num_reg[HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.load) begin
            raw_out_reg <= raw_hold_reg;
            idx_out_reg <= (divisor_reg == '0) ? '0 : rem_reg;
        end
    end

    assign m_bucket_index = idx_out_reg;
    assign m_raw_hash     = raw_out_reg;

endmodule

`default_nettype wire

// ===== design/sbh_checker.sv =====
// ----------------------------------------------------------------------------
// sbh_checker
// Port-level checks on the hash core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "string_bucket_hash_core_defines.svh"

module sbh_checker
    import sbh_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic [BYTE_W-1:0] s_char_byte,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [IDX_W-1:0]  m_bucket_index,
    input wire logic [HASH_W-1:0] m_raw_hash
);

    logic term_beat;
    logic byte_beat;

    assign term_beat = s_valid && s_ready && (s_char_byte == '0);
    assign byte_beat = s_valid && s_ready && (s_char_byte != '0);

    // Reset drops the output beat
    `SBH_ASSERT_NXT_ALL(a_reset_idle, aclk, !aresetn, !m_valid)

    // Stalled result holds
    `SBH_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_bucket_index) && $stable(m_raw_hash))

    // Terminator starts the divide and blocks input
    `SBH_ASSERT_NXT(a_term_busy, aclk, aresetn, term_beat, !s_ready)

    // Ordinary bytes stream without a bubble
    `SBH_ASSERT_NXT(a_byte_stream, aclk, aresetn, byte_beat, s_ready)

    // A remainder never exceeds its dividend
    `SBH_ASSERT_IMP(a_idx_range, aclk, aresetn, m_valid,
        HASH_W'(m_bucket_index) <= m_raw_hash)

endmodule

bind string_bucket_hash_core sbh_checker u_sbh_checker (.*);

`default_nettype wire

// ===== bench/string_bucket_hash_core_tb.sv =====
// ----------------------------------------------------------------------------
// string_bucket_hash_core_tb
// Self-checking bench for the byte-serial bucket hash core. Names are
// streamed in one byte per beat and each terminator's result is checked
// against a local hash/modulo predictor. The run covers several table sizes
// (including 1, 65535 and zero) and changes the sender and receiver pacing
// from one phase to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module string_bucket_hash_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sbh_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_BYTES   = 270;

    typedef struct packed {
        logic [IDX_W-1:0]  bucket;
        logic [HASH_W-1:0] hash;
    } bucket_result_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]  cfg_wr_data   = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_char_byte   = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [IDX_W-1:0]  m_bucket_index;
    logic [HASH_W-1:0] m_raw_hash;

    // Predictor state and pacing knobs
    logic [HASH_W-1:0] name_hash    = '0;
    logic [IDX_W-1:0]  bucket_count = TABLE_SIZE_RST;
    bucket_result_t    pending_results[$];
    int                send_idle_pct  = 21;
    int                recv_stall_pct = 46;
    int                mismatch_count = 0;
    int                cycle_count    = 0;

    string_bucket_hash_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket_index (m_bucket_index),
        .m_raw_hash     (m_raw_hash)
    );

    always #10 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("string_bucket_hash_core_tb: FAIL");
            $finish;
        end
    end

    // Shift the hash up by 12, add the byte, fold the top byte back in
    function automatic logic [HASH_W-1:0] fold_char(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] c);
        logic [31:0] v;
        v = {h[19:0], 12'h000} + {24'h000000, c};
        if (v[31:24] != 8'h00) begin
            v = {24'h000000, v[31:24]} ^ v;
        end
        return v[HASH_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Advance the predictor on an accepted byte
    task automatic predict_char(input logic [BYTE_W-1:0] c);
        bucket_result_t r;
        if (c != 8'h00) begin
            name_hash = fold_char(name_hash, c);
        end else begin
            r.hash   = name_hash;
            r.bucket = (bucket_count == 0) ? '0 : IDX_W'(name_hash % bucket_count);
            pending_results.push_back(r);
            name_hash = '0;
        end
    endtask

    // Drive one byte beat, idling first at the current rate
    task automatic send_byte(input logic [BYTE_W-1:0] c);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid     <= 1'b0;
            s_char_byte <= BYTE_W'($urandom);
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_byte <= c;
        do @(posedge aclk); while (!s_ready);
        predict_char(c);
    endtask

    task automatic park_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write the table size once the core has gone quiet
    task automatic set_table_size(input logic [IDX_W-1:0] size);
        park_sender();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        bucket_count = size;
    endtask

    task automatic send_name(input int len);
        logic [BYTE_W-1:0] c;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0:       c = 8'hff;
                1:       c = 8'h01;
                default: c = BYTE_W'($urandom_range(255, 1));
            endcase
            send_byte(c);
        end
        send_byte(8'h00);
    endtask

    // Hand-picked names: empty, byte extremes, folding runs, plain text
    task automatic test_directed_names();
        logic [BYTE_W-1:0] seq [23] = '{
            8'h00,
            8'h01, 8'h00,
            8'hff, 8'h00,
            8'hff, 8'hff, 8'hff, 8'h00,
            8'h80, 8'h7f, 8'h00,
            8'h68, 8'h61, 8'h73, 8'h68, 8'h00,
            8'h00,
            8'h55, 8'haa, 8'h55, 8'haa, 8'h00
        };
        foreach (seq[i]) send_byte(seq[i]);
        park_sender();
        wait_results();
    endtask

    // Table size at its limits, zero included
    task automatic test_table_extremes();
        logic [IDX_W-1:0] sizes [5] = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'd127};
        foreach (sizes[i]) begin
            set_table_size(sizes[i]);
            send_byte(8'h00);
            send_name(1);
            send_name(4);
            send_name(16);
            send_name($urandom_range(6, 1));
        end
        park_sender();
        wait_results();
    endtask

    // Random names, mostly short, a few long; sometimes hold until drained
    task automatic run_random_names(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(99) < 5) ? $urandom_range(48, 16) : $urandom_range(10, 0);
            send_name(len);
            sent += len + 1;
            if ($urandom_range(99) < 3) begin
                park_sender();
                wait_results();
            end
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_table_size(IDX_W'($urandom_range(65535, 1)));
        run_random_names(PHASE_BYTES);
        set_table_size(IDX_W'($urandom_range(16, 1)));
        run_random_names(PHASE_BYTES);
        park_sender();
        wait_results();
    endtask

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        bucket_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result bucket %0d hash %06h",
                                          m_bucket_index, m_raw_hash));
            end else begin
                want = pending_results.pop_front();
                if (m_bucket_index !== want.bucket) begin
                    report_mismatch($sformatf("bucket_index %0d, want %0d (hash %06h)",
                                              m_bucket_index, want.bucket, want.hash));
                end
                if (m_raw_hash !== want.hash) begin
                    report_mismatch($sformatf("raw_hash %06h, want %06h",
                                              m_raw_hash, want.hash));
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_names();
        test_table_extremes();
        test_random_traffic(21, 46);
        test_random_traffic(46, 21);
        test_random_traffic(0, 0);

        park_sender();
        wait_results();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("string_bucket_hash_core_tb: PASS");
        end else begin
            $display("string_bucket_hash_core_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
